/* rtl/glmt_pkg.sv */
// ----------------------------------------------------------------------------
// glmt_pkg
// Shared types, codes and helpers for the longest-match tokenizer.
// ----------------------------------------------------------------------------
package glmt_pkg;

  localparam int MaxEntries  = 1024;
  localparam int IdxW        = $clog2(MaxEntries);
  localparam int CountW      = IdxW + 1;
  localparam int MaxEntryLen = 8;

  // operation codes carried on the input tuser
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_TEXT   = 2'd1,
    OP_EOT    = 2'd2,
    OP_DECODE = 2'd3
  } op_t;

  // result kinds carried on the output tuser
  localparam logic [2:0] KIND_TOKEN   = 3'd0;
  localparam logic [2:0] KIND_BYTE    = 3'd1;
  localparam logic [2:0] KIND_EMPTY   = 3'd2;
  localparam logic [2:0] KIND_EOT     = 3'd3;
  localparam logic [2:0] KIND_NOMATCH = 3'd4;
  localparam logic [2:0] KIND_RANGE   = 3'd5;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MRES,
    ST_EOT,
    ST_DEC,
    ST_RANGE
  } state_t;

  // one queued input word
  typedef struct packed {
    op_t         op;
    logic [63:0] entry_bytes;
    logic [3:0]  entry_len;
    logic [7:0]  text_byte;
    logic [15:0] token_id;
  } item_t;

  // mask that keeps the low len bytes of a 64-bit word
  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (len > 4'(b)) m[b*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

/* rtl/greedy_longest_match_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// greedy_longest_match_tokenizer_core
// Greedy longest-match tokenizer with vocabulary load and token decode.
// ----------------------------------------------------------------------------
// Usage: words enter on the in_ stream; in_tuser gives the operation (load
// entry, text byte, end of text, decode id). Results leave on the out_ stream;
// out_tuser gives the result kind and out_tlast marks the final result of a
// word. Words are queued two deep in front of the execution sequencer, and
// one output register lets a word be taken while a result waits.
// A text byte that closes a window starts one match attempt: a scan that
// reads one vocabulary entry a cycle from the single memory port, with
// registered read data, and then emits the result. A decode gives one result
// per byte of the entry (one empty result for an empty entry); end of text
// runs one match attempt per token or no-match result, then emits the
// end-of-text result.
// Reset clears the vocabulary count, window and error state; memory contents
// need no clearing. When the receiver stalls, the result holds in the output
// register and the sequencer waits, then the input queue fills and in_tready
// drops.
// ----------------------------------------------------------------------------
module greedy_longest_match_tokenizer_core import glmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // entry_bytes, entry_len, text_byte, token_id
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // out_token, out_byte, error_offset
  output logic [2:0]  out_tuser,  // result_kind
  output logic        out_tlast
);

  logic  head_vld, head_pop;
  item_t head;

  glmt_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .head_vld, .head, .head_pop
  );

  glmt_back u_back (
    .clk, .rst_n, .head_vld, .head, .head_pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

endmodule

/* rtl/glmt_front.sv */
// ----------------------------------------------------------------------------
// glmt_front
// Input side: takes words and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module glmt_front import glmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic [1:0]  in_tuser,
  output logic        head_vld,
  output item_t       head,
  input  logic        head_pop
);

  item_t      q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      in_item;

  // unpack the incoming word
  always_comb begin
    in_item.op          = op_t'(in_tuser);
    in_item.entry_bytes = in_tdata[63:0];
    in_item.entry_len   = in_tdata[67:64];
    in_item.text_byte   = in_tdata[75:68];
    in_item.token_id    = in_tdata[91:76];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign head_vld  = (cnt_r != 2'd0);
  assign head      = q_r[rp_r];

  // queue pointers
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = head_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(head_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= in_item;
  end

endmodule

/* rtl/glmt_back.sv */
// ----------------------------------------------------------------------------
// glmt_back
// Execution side: vocabulary memory, text window, match scan and decode.
// ----------------------------------------------------------------------------
module glmt_back import glmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_vld,
  input  item_t       head,
  output logic        head_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  // vocabulary memory
  logic [67:0]     mem [MaxEntries];
  logic [67:0]     rd_data_r;
  logic            rd_en, wr_en;
  logic [IdxW-1:0] rd_addr;
  logic [67:0]     wr_data;

  state_t          state_r, state_nxt;
  logic [CountW-1:0] count_r, idx_r;
  logic [3:0]      longest_r, fill_r, maxl_r, best_len_r;
  logic [63:0]     win_r;
  logic [31:0]     off_r;
  logic            disc_r, eot_r, rd_pend_r;
  logic [IdxW-1:0] rd_id_r, best_id_r;
  logic [2:0]      dec_i_r;

  // output register
  logic            ovld_r;
  logic [2:0]      okind_r, okind_nxt;
  logic [9:0]      otok_r, otok_nxt;
  logic [7:0]      obyte_r, obyte_nxt;
  logic [31:0]     ooff_r, ooff_nxt;
  logic            olast_r, olast_nxt;
  logic            emit_ok, emit;

  logic [3:0]      load_len, fill_app, fill_left, maxl_new, mem_len;
  logic [63:0]     win_app, mem_str;
  logic            match_go, range_err, issue, hit;
  logic [32:0]     off_sum;

  assign emit_ok = !ovld_r || out_tready;
  assign emit    = emit_ok && (state_r == ST_MRES || state_r == ST_EOT ||
                               state_r == ST_RANGE || state_r == ST_DEC);
  assign mem_str = rd_data_r[63:0];
  assign mem_len = rd_data_r[67:64];

  // text append and derived values
  always_comb begin
    load_len = (head.entry_len > 4'(MaxEntryLen)) ? 4'(MaxEntryLen) : head.entry_len;
    win_app  = win_r;
    fill_app = fill_r;
    if (fill_r < 4'd8) begin
      win_app  = win_r | ({56'd0, head.text_byte} << {fill_r[2:0], 3'b000});
      fill_app = fill_r + 4'd1;
    end
    match_go  = (fill_app >= longest_r);
    range_err = (head.token_id >= 16'(count_r));
    fill_left = fill_r - best_len_r;
    off_sum   = {1'b0, off_r} + {29'd0, best_len_r};
    issue     = (state_r == ST_SCAN) && (idx_r < count_r);
    hit       = rd_pend_r && (mem_len != 4'd0) && (mem_len <= maxl_r) &&
                (mem_len > best_len_r) &&
                (mem_str == (win_r & byte_mask(mem_len)));
    maxl_new  = longest_r;
    if (state_r == ST_IDLE) begin
      if (head.op == OP_TEXT && fill_app < longest_r) maxl_new = fill_app;
      if (head.op == OP_EOT && fill_r < longest_r) maxl_new = fill_r;
    end else if (fill_left < longest_r) begin
      maxl_new = fill_left;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (head_vld) begin
          unique case (head.op)
            OP_LOAD:   state_nxt = ST_IDLE;
            OP_TEXT:   state_nxt = (!disc_r && match_go) ? ST_SCAN : ST_IDLE;
            OP_EOT:    state_nxt = (!disc_r && fill_r != 4'd0) ? ST_SCAN : ST_EOT;
            OP_DECODE: state_nxt = range_err ? ST_RANGE : ST_DEC;
          endcase
        end
      end
      ST_SCAN: begin
        if (idx_r == count_r && !rd_pend_r) state_nxt = ST_MRES;
      end
      ST_MRES: begin
        if (emit_ok) begin
          if (!eot_r) state_nxt = ST_IDLE;
          else if (best_len_r != 4'd0 && fill_left != 4'd0) state_nxt = ST_SCAN;
          else state_nxt = ST_EOT;
        end
      end
      ST_EOT:   if (emit_ok) state_nxt = ST_IDLE;
      ST_RANGE: if (emit_ok) state_nxt = ST_IDLE;
      ST_DEC: begin
        if (emit_ok && (mem_len == 4'd0 || 4'(dec_i_r) + 4'd1 >= mem_len))
          state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    head_pop = (state_r == ST_IDLE) && head_vld;
    wr_en    = head_pop && head.op == OP_LOAD && count_r < CountW'(MaxEntries);
    wr_data  = {load_len, head.entry_bytes & byte_mask(load_len)};
    rd_en    = issue || (head_pop && head.op == OP_DECODE);
    rd_addr  = issue ? idx_r[IdxW-1:0] : head.token_id[IdxW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[IdxW-1:0]] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      longest_r <= 4'd0;
      fill_r    <= 4'd0;
      win_r     <= '0;
      off_r     <= '0;
      disc_r    <= 1'b0;
      rd_pend_r <= 1'b0;
      ovld_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= issue;
      if (emit) ovld_r <= 1'b1;
      else if (out_tready) ovld_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (head_vld) begin
            unique case (head.op)
              OP_LOAD: begin
                if (wr_en) begin
                  count_r <= count_r + CountW'(1);
                  if (load_len > longest_r) longest_r <= load_len;
                end
              end
              OP_TEXT: begin
                if (!disc_r) begin
                  win_r  <= win_app;
                  fill_r <= fill_app;
                end
              end
              OP_EOT, OP_DECODE: ;
            endcase
          end
        end
        ST_MRES: begin
          if (emit_ok) begin
            if (best_len_r != 4'd0) begin
              win_r  <= (best_len_r == 4'd8) ? '0 : win_r >> {best_len_r[2:0], 3'b000};
              fill_r <= fill_left;
              off_r  <= off_sum[32] ? 32'hffff_ffff : off_sum[31:0];
            end else begin
              win_r  <= '0;
              fill_r <= 4'd0;
              disc_r <= 1'b1;
            end
          end
        end
        ST_EOT: begin
          if (emit_ok) begin
            win_r  <= '0;
            fill_r <= 4'd0;
            off_r  <= '0;
            disc_r <= 1'b0;
          end
        end
        ST_RANGE, ST_DEC: ;
        ST_SCAN: ;
        default: ;
      endcase
    end
  end

  // scan and decode datapath
  always_ff @(posedge clk) begin
    rd_id_r <= idx_r[IdxW-1:0];
    if (state_nxt == ST_SCAN && state_r != ST_SCAN) begin
      idx_r      <= '0;
      best_len_r <= 4'd0;
      maxl_r     <= maxl_new;
      if (state_r == ST_IDLE) eot_r <= (head.op == OP_EOT);
    end else begin
      if (issue) idx_r <= idx_r + CountW'(1);
      if (hit) begin
        best_len_r <= mem_len;
        best_id_r  <= rd_id_r;
      end
    end
    if (state_r == ST_IDLE) dec_i_r <= 3'd0;
    else if (state_r == ST_DEC && emit_ok) dec_i_r <= dec_i_r + 3'd1;
  end

  // result fields for the word being emitted
  always_comb begin
    okind_nxt = KIND_EOT;
    otok_nxt  = '0;
    obyte_nxt = '0;
    ooff_nxt  = '0;
    olast_nxt = 1'b1;
    unique case (state_r)
      ST_MRES: begin
        olast_nxt = !eot_r;
        if (best_len_r != 4'd0) begin
          okind_nxt = KIND_TOKEN;
          otok_nxt  = 10'(best_id_r);
        end else begin
          okind_nxt = KIND_NOMATCH;
          ooff_nxt  = off_r;
        end
      end
      ST_EOT:   okind_nxt = KIND_EOT;
      ST_RANGE: okind_nxt = KIND_RANGE;
      ST_DEC: begin
        if (mem_len == 4'd0) begin
          okind_nxt = KIND_EMPTY;
        end else begin
          okind_nxt = KIND_BYTE;
          obyte_nxt = mem_str[{dec_i_r, 3'b000} +: 8];
          olast_nxt = (4'(dec_i_r) + 4'd1 >= mem_len);
        end
      end
      default: okind_nxt = KIND_EOT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      okind_r <= okind_nxt;
      otok_r  <= otok_nxt;
      obyte_r <= obyte_nxt;
      ooff_r  <= ooff_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {6'd0, ooff_r, obyte_r, otok_r};

endmodule
